// ===== rtl/cdf_pkg.sv =====
// Shared types, constants and the CRC-8 byte update for the delimited framer.
package cdf_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam logic [7:0]  DELIM_RESET   = 8'h7E;
    localparam logic [7:0]  CRC_POLY      = 8'h8C;
    localparam logic [7:0]  CRC_INIT      = 8'h00;
    localparam int unsigned QUEUE_DEPTH_D = 2;

    // Kind of an output byte, carried on the master-side tuser.
    typedef enum logic [1:0] {
        KIND_DELIM = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_CRC   = 2'd2
    } t_kind;

    // Emission step of the back end for the command at the queue head.
    typedef enum logic [1:0] {
        ST_FIRST = 2'd0,
        ST_DATA  = 2'd1,
        ST_CRC   = 2'd2,
        ST_CLOSE = 2'd3
    } t_state;

    // One classified payload byte, handed from the front end to the back end.
    typedef struct packed {
        logic [7:0] data;
        logic [7:0] crc;
        logic       open;
        logic       last;
    } t_cmd;

    // Reflected CRC-8 update over one byte, least significant bit first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc_in;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = {1'b0, c[7:1]};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/cdf_front.sv =====
// Front end: accepts payload beats, tracks the open packet and its running CRC.
module cdf_front
    import cdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data,
    input  logic       i_last,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  logic       i_full
);

    logic       r_in_packet;
    logic       n_in_packet;
    logic [7:0] r_crc;
    logic [7:0] n_crc;
    logic [7:0] crc_base;
    logic [7:0] crc_new;

    assign o_ready  = !i_full;
    assign o_push   = i_valid && !i_full;
    assign crc_base = r_in_packet ? r_crc : CRC_INIT;
    assign crc_new  = crc8_byte(crc_base, i_data);

    always_comb begin
        o_cmd.data = i_data;
        o_cmd.crc  = crc_new;
        o_cmd.open = !r_in_packet;
        o_cmd.last = i_last;
    end

    always_comb begin
        n_in_packet = r_in_packet;
        n_crc       = r_crc;
        if (o_push) begin
            n_in_packet = !i_last;
            n_crc       = i_last ? CRC_INIT : crc_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_packet <= 1'b0;
            r_crc       <= CRC_INIT;
        end else begin
            r_in_packet <= n_in_packet;
            r_crc       <= n_crc;
        end
    end

    // Between packets the running CRC must sit at its initial value.
    a_crc_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_packet |-> (r_crc == CRC_INIT))
        else $error("running CRC not cleared outside a packet");

endmodule

// ===== rtl/cdf_queue.sv =====
// Short command queue that decouples the front end from the back end.
module cdf_queue
    import cdf_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_D
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("command pushed into a full queue");

endmodule

// ===== rtl/cdf_back.sv =====
// Back end: expands each command into a data beat plus any delimiter and CRC beats.
module cdf_back
    import cdf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_delim,
    input  logic       i_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output t_kind      o_kind,
    output logic       o_last
);

    t_state     r_state;
    t_state     n_state;
    logic       r_valid;
    logic [7:0] r_byte;
    t_kind      r_kind;
    logic       r_end;
    logic       out_free;
    logic       emit;
    logic [7:0] e_byte;
    t_kind      e_kind;
    logic       e_end;
    logic       e_pop;
    t_state     e_next;

    assign out_free = !r_valid || i_ready;
    assign emit     = i_valid && out_free;
    assign o_pop    = emit && e_pop;
    assign o_valid  = r_valid;
    assign o_byte   = r_byte;
    assign o_kind   = r_kind;
    assign o_last   = r_end;

    // Beat selection for the head command; a fresh command opens with a
    // delimiter only if no packet was open when it arrived.
    always_comb begin
        e_byte = i_cmd.data;
        e_kind = KIND_DATA;
        e_end  = !i_cmd.last;
        e_pop  = !i_cmd.last;
        e_next = i_cmd.last ? ST_CRC : ST_FIRST;
        unique case (r_state)
            ST_FIRST: begin
                if (i_cmd.open) begin
                    e_byte = i_delim;
                    e_kind = KIND_DELIM;
                    e_end  = 1'b0;
                    e_pop  = 1'b0;
                    e_next = ST_DATA;
                end
            end
            ST_DATA: begin
            end
            ST_CRC: begin
                e_byte = i_cmd.crc;
                e_kind = KIND_CRC;
                e_end  = 1'b0;
                e_pop  = 1'b0;
                e_next = ST_CLOSE;
            end
            ST_CLOSE: begin
                e_byte = i_delim;
                e_kind = KIND_DELIM;
                e_end  = 1'b1;
                e_pop  = 1'b1;
                e_next = ST_FIRST;
            end
            default: begin
            end
        endcase
        n_state = emit ? e_next : r_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_FIRST;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_free) begin
                r_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte <= e_byte;
            r_kind <= e_kind;
            r_end  <= e_end;
        end
    end

    // Once a command has started, it stays at the queue head until its final beat.
    a_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_FIRST) |-> i_valid)
        else $error("queue head lost in the middle of a command");

    a_crc_then_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && r_state == ST_CRC) |=> (r_state == ST_CLOSE))
        else $error("CRC beat not followed by the closing delimiter");

endmodule

// ===== rtl/crc8_delimited_framer_unit.sv =====
// Top level of the CRC-8 delimited packet framer.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata = payload byte, tlast = last payload byte of the packet
//  m_axis    out        tdata = line byte, tuser = kind (delimiter/data/CRC),
//                       tlast = final beat produced for one input beat
//  cfg       in         i_cfg_data = delimiter byte
//
// A payload byte yields one to four beats, set by the back-end sequencer; a packet
// of a single byte yields all four: delimiter, data, CRC and closing delimiter.
// The front end computes the CRC in the accept cycle and runs ahead through the
// command queue while the output register waits on m_axis_tready.
// Synchronous active-low reset empties the queue, closes any open packet and sets
// the delimiter to 0x7E. Configuration writes are always accepted.
module crc8_delimited_framer_unit
    import cdf_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_D
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] m_axis_tuser,   // [1:0] byte_kind
    output logic       m_axis_tlast,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    logic [7:0] r_delim;
    logic       push;
    logic       full;
    logic       pop;
    logic       q_valid;
    t_cmd       push_cmd;
    t_cmd       head_cmd;
    t_kind      kind;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tuser = kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim <= DELIM_RESET;
        end else if (i_cfg_valid) begin
            r_delim <= i_cfg_data;
        end
    end

    cdf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_push  (push),
        .o_cmd   (push_cmd),
        .i_full  (full)
    );

    cdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    cdf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_delim (r_delim),
        .i_valid (q_valid),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_kind  (kind),
        .o_last  (m_axis_tlast)
    );

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the CRC-8 delimited packet framer.
module tb;
    import cdf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT    = 100000;
    localparam int unsigned IDLE_SETTLE    = 6;
    localparam int unsigned END_SETTLE     = 20;
    localparam int unsigned RAND_PHASES    = 5;
    localparam int unsigned RAND_PER_PHASE = 16;
    localparam int unsigned MAX_REPORTS    = 10;

    typedef enum logic { ROW_ITEM = 1'b0, ROW_CFG = 1'b1 } t_row_kind;

    typedef enum logic [1:0] {
        RX_OPEN   = 2'd0,
        RX_COIN   = 2'd1,
        RX_THIRD  = 2'd2,
        RX_SPARSE = 2'd3
    } t_rx_mode;

    // One line byte as the block should present it on the master side.
    typedef struct packed {
        logic [7:0] out_byte;
        t_kind      kind;
        logic       run_end;
    } t_line_beat;

    // One row of the directed table. Rows with typed set carry the line bytes of a
    // single-byte packet written out by hand.
    typedef struct packed {
        t_row_kind  rk;
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [7:0] t_delim;
        logic [7:0] t_crc;
    } t_stim_row;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] data_byte
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;            // [7:0] out_byte
    logic [1:0] m_axis_tuser;            // [1:0] byte_kind
    logic       m_axis_tlast;
    logic       i_cfg_valid   = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data    = 8'h00;

    // Sideband that travels with each driven beat, telling the checker to use
    // hand-written line bytes for it.
    logic       drv_typed   = 1'b0;
    logic [7:0] drv_t_delim = 8'h00;
    logic [7:0] drv_t_crc   = 8'h00;

    // Framer model state.
    logic [7:0] model_delim = DELIM_RESET;
    logic [7:0] model_crc   = CRC_INIT;
    logic       model_open  = 1'b0;
    t_line_beat frame_beats [0:3];
    int         frame_n;

    t_line_beat line_q [$];
    t_stim_row  directed_q [$];

    int unsigned cycle_cnt  = 0;
    int unsigned err_count  = 0;
    int unsigned burst_left = 0;
    int unsigned rx_left    = 0;
    t_rx_mode    rx_mode    = RX_OPEN;

    crc8_delimited_framer_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("FAIL crc8_delimited_framer_unit");
            $finish;
        end
    end

    // Works out the line bytes for one accepted payload byte and advances the model.
    task automatic frame_predict(input logic [7:0] d, input logic l);
        logic [7:0] c;
        logic       fb;
        frame_n = 0;
        if (!model_open) begin
            frame_beats[frame_n] = '{model_delim, KIND_DELIM, 1'b0};
            frame_n++;
            model_crc = CRC_INIT;
        end
        frame_beats[frame_n] = '{d, KIND_DATA, 1'b0};
        frame_n++;
        c = model_crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c  = {1'b0, c[7:1]};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        model_crc = c;
        if (l) begin
            frame_beats[frame_n] = '{model_crc, KIND_CRC, 1'b0};
            frame_n++;
            frame_beats[frame_n] = '{model_delim, KIND_DELIM, 1'b0};
            frame_n++;
            model_crc  = CRC_INIT;
            model_open = 1'b0;
        end else begin
            model_open = 1'b1;
        end
        frame_beats[frame_n - 1].run_end = 1'b1;
    endtask

    // The receiver switches at random between stall patterns, drawing a new one whenever rx_left runs out.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(20, 80);
        end
        rx_left = rx_left - 1;
        case (rx_mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
            RX_THIRD:  m_axis_tready <= (cycle_cnt % 3 == 0);
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Predicts on every accepted input beat and checks every accepted output beat.
    always @(posedge i_clk) begin
        t_line_beat want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                model_delim = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                frame_predict(s_axis_tdata, s_axis_tlast);
                if (drv_typed) begin
                    frame_beats[0] = '{drv_t_delim, KIND_DELIM, 1'b0};
                    frame_beats[1] = '{s_axis_tdata, KIND_DATA, 1'b0};
                    frame_beats[2] = '{drv_t_crc, KIND_CRC, 1'b0};
                    frame_beats[3] = '{drv_t_delim, KIND_DELIM, 1'b1};
                    frame_n = 4;
                end
                for (int k = 0; k < frame_n; k++) begin
                    line_q.push_back(frame_beats[k]);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (line_q.size() == 0) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS) begin
                        $display("unexpected beat: byte %h kind %0d last %b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end else begin
                    want = line_q.pop_front();
                    if (m_axis_tdata !== want.out_byte || m_axis_tuser !== want.kind ||
                        m_axis_tlast !== want.run_end) begin
                        err_count++;
                        if (err_count <= MAX_REPORTS) begin
                            $display("mismatch: expected byte %h kind %0d last %b, got %h %0d %b",
                                     want.out_byte, want.kind, want.run_end,
                                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
                        end
                    end
                end
            end
        end
    end

    // Bursts of back-to-back beats separated by random gaps.
    task automatic send_beat(input logic [7:0] d, input logic l, input logic typed,
                             input logic [7:0] td, input logic [7:0] tc);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= l;
        drv_typed     <= typed;
        drv_t_delim   <= td;
        drv_t_crc     <= tc;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        burst_left = burst_left - 1;
    endtask

    // Stops the sender and waits until every predicted line byte has come out.
    task automatic drain_line;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (line_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_delim(input logic [7:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic add_item(input logic [7:0] d, input logic l);
        directed_q.push_back('{ROW_ITEM, d, l, 1'b0, 8'h00, 8'h00});
    endtask

    task automatic add_typed(input logic [7:0] d, input logic [7:0] td, input logic [7:0] tc);
        directed_q.push_back('{ROW_ITEM, d, 1'b1, 1'b1, td, tc});
    endtask

    task automatic add_cfg(input logic [7:0] v);
        directed_q.push_back('{ROW_CFG, v, 1'b0, 1'b0, 8'h00, 8'h00});
    endtask

    initial begin : stimulus
        t_stim_row   row;
        logic [7:0]  dv;
        logic [7:0]  d;
        int unsigned plen;
        int unsigned n;

        // A zero byte under the reset delimiter frames to a known sequence.
        add_typed(8'h00, 8'h7E, 8'h00);
        add_item(8'hFF, 1'b1);
        // The closing byte of this packet equals the delimiter and is not escaped.
        add_item(8'h01, 1'b0);
        add_item(8'h80, 1'b0);
        add_item(8'h7E, 1'b1);
        // The delimiter changes while a packet is open.
        add_item(8'hAA, 1'b0);
        add_cfg(8'h00);
        add_item(8'h55, 1'b0);
        add_item(8'h00, 1'b1);
        add_typed(8'h00, 8'h00, 8'h00);
        add_cfg(8'hFF);
        add_item(8'hFF, 1'b1);
        add_item(8'h00, 1'b0);
        add_item(8'hFF, 1'b0);
        add_item(8'h0F, 1'b0);
        add_item(8'hF0, 1'b1);
        add_cfg(8'hA5);
        add_item(8'hA5, 1'b1);
        add_item(8'h5A, 1'b0);
        add_item(8'hA5, 1'b1);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_q[i]) begin
            row = directed_q[i];
            if (row.rk == ROW_CFG) begin
                drain_line();
                write_delim(row.data);
            end else begin
                send_beat(row.data, row.last, row.typed, row.t_delim, row.t_crc);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 3))
                0:       dv = 8'h00;
                1:       dv = 8'hFF;
                2:       dv = DELIM_RESET;
                default: dv = 8'($urandom_range(0, 255));
            endcase
            drain_line();
            write_delim(dv);
            n = 0;
            // Phases end on the item count, so a packet may stay open across a write.
            while (n < RAND_PER_PHASE) begin
                plen = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
                for (int j = 0; j < plen && n < RAND_PER_PHASE; j++) begin
                    d = ($urandom_range(0, 9) == 0) ? dv : 8'($urandom_range(0, 255));
                    send_beat(d, j == plen - 1, 1'b0, 8'h00, 8'h00);
                    n++;
                end
            end
        end

        drain_line();
        repeat (END_SETTLE) @(posedge i_clk);
        if (line_q.size() != 0) begin
            err_count++;
            $display("%0d line bytes never came out", line_q.size());
        end
        if (err_count == 0) begin
            $display("PASS crc8_delimited_framer_unit");
        end else begin
            $display("FAIL crc8_delimited_framer_unit");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/cdf_pkg.sv
rtl/cdf_front.sv
rtl/cdf_queue.sv
rtl/cdf_back.sv
rtl/crc8_delimited_framer_unit.sv
test/tb.sv
